[rtl/dsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the directional squared difference block.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam int PIXEL_FIELD_W = 16;
  localparam int RESULT_W      = 32;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 13;
  localparam int OUT_ROW_W     = 12;
  localparam int QUEUE_DEPTH   = 2;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [PIXEL_FIELD_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] diff_left_sq;
    logic [RESULT_W-1:0] diff_up_sq;
    logic [RESULT_W-1:0] diff_up_right_half;
    logic [RESULT_W-1:0] diff_down_right_half;
    logic                frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             restart;
  } frame_cfg_t;

endpackage
`default_nettype wire

[rtl/directional_squared_difference.sv]
`default_nettype none
// Ordering: the result of pixel n leaves with input item n+width+1, which then
//   passes the queue slot and the store read, difference and square registers.
// Throughput: one item per cycle unless stalled, set by one read and one write
//   of each line store per item; a padding tick inside the frame is taken and dropped.
// Reset: counters and window registers clear at once and the registers take
//   640 x 480; the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// directional_squared_difference
// Four directional squared differences per pixel of a raster stream.
// ----------------------------------------------------------------------------
module directional_squared_difference #(
  parameter int MAX_WIDTH  = dsd_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = dsd_pkg::PIXEL_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [dsd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [dsd_pkg::CFG_W-1:0]     cfg_value_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  dsd_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output dsd_pkg::out_item_t           out_item_o
);

  localparam int PIX_W =
    (PIXEL_BITS < dsd_pkg::PIXEL_FIELD_W) ? PIXEL_BITS : dsd_pkg::PIXEL_FIELD_W;
  localparam int QW = 1 + $clog2(MAX_WIDTH) + PIX_W;

  dsd_pkg::frame_cfg_t frame_cfg;
  logic                push, full, q_valid, q_pop;
  logic [QW-1:0]       push_data, q_data;

  dsd_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .PIX_W    (PIX_W),
    .QW       (QW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_value_i(cfg_value_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data),
    .cfg_o      (frame_cfg)
  );

  dsd_queue #(
    .DATA_W(QW),
    .DEPTH (dsd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  dsd_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .PIX_W    (PIX_W),
    .QW       (QW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (frame_cfg),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

[rtl/dsd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_front
// Frame registers, input position counters and item classification.
// ----------------------------------------------------------------------------
module dsd_front #(
  parameter int MAX_WIDTH = dsd_pkg::MAX_WIDTH_DEF,
  parameter int PIX_W     = dsd_pkg::PIXEL_BITS_DEF,
  parameter int QW        = 1 + $clog2(MAX_WIDTH) + PIX_W
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [dsd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [dsd_pkg::CFG_W-1:0]       cfg_value_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  dsd_pkg::in_item_t              in_item_i,
  input  wire                            full_i,
  output logic                           push_o,
  output logic [QW-1:0]                  push_data_o,
  output dsd_pkg::frame_cfg_t            cfg_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = ((CW > dsd_pkg::CFG_W) ? CW : dsd_pkg::CFG_W) + 1;
  localparam int WIDTH_RST =
    (dsd_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : dsd_pkg::RESET_WIDTH;

  logic [dsd_pkg::CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]             in_column_q;
  logic [dsd_pkg::ROW_W-1:0] in_row_q;

  logic                      accept, draining, drop, emit, take, frame_done, wrap;
  logic                      cfg_hit;
  logic [PIX_W-1:0]          x;
  logic [XW-1:0]             col_next;
  logic [dsd_pkg::CFG_W-1:0] width_clamp, height_clamp;
  logic [31:0]               value_ext;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign draining   = in_row_q >= height_q;
  assign drop       = (in_item_i.op == dsd_pkg::OP_PAD) && !draining;
  assign take       = accept && !drop;
  assign x          = draining ? '0 : in_item_i.pixel[PIX_W-1:0];
  assign emit       = (in_row_q >= dsd_pkg::ROW_W'(2)) ||
                      ((in_row_q == dsd_pkg::ROW_W'(1)) && (in_column_q != '0));
  // the first item two rows past the last frame row drains the frame's final result
  assign frame_done = in_row_q == (height_q + dsd_pkg::ROW_W'(1));
  assign col_next   = XW'(in_column_q) + XW'(1);
  assign wrap       = col_next >= XW'(width_q);

  assign push_o      = take;
  assign push_data_o = {emit, in_column_q, x};

  assign cfg_hit = cfg_we_i && ((cfg_index_i == dsd_pkg::CFG_IMAGE_WIDTH) ||
                                (cfg_index_i == dsd_pkg::CFG_IMAGE_HEIGHT));

  assign cfg_o.width   = width_q;
  assign cfg_o.height  = height_q;
  assign cfg_o.restart = cfg_hit;

  always_comb begin
    value_ext = 32'(cfg_value_i);
    if (value_ext == 32'd0) begin
      width_clamp  = dsd_pkg::CFG_W'(1);
      height_clamp = dsd_pkg::CFG_W'(1);
    end else begin
      width_clamp  = (value_ext > 32'(MAX_WIDTH)) ?
                     dsd_pkg::CFG_W'(MAX_WIDTH) : cfg_value_i;
      height_clamp = (value_ext > 32'(dsd_pkg::MAX_HEIGHT)) ?
                     dsd_pkg::CFG_W'(dsd_pkg::MAX_HEIGHT) : cfg_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= dsd_pkg::CFG_W'(WIDTH_RST);
      height_q    <= dsd_pkg::CFG_W'(dsd_pkg::RESET_HEIGHT);
      in_column_q <= '0;
      in_row_q    <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == dsd_pkg::CFG_IMAGE_WIDTH) begin
        width_q <= width_clamp;
      end else begin
        height_q <= height_clamp;
      end
      in_column_q <= '0;
      in_row_q    <= '0;
    end else if (take) begin
      if (frame_done) begin
        in_column_q <= '0;
        in_row_q    <= '0;
      end else if (wrap) begin
        in_column_q <= '0;
        if (in_row_q <= height_q) begin
          in_row_q <= in_row_q + dsd_pkg::ROW_W'(1);
        end
      end else begin
        in_column_q <= col_next[CW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/dsd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_queue
// Short queue between the classifying front and the processing back.
// ----------------------------------------------------------------------------
module dsd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = dsd_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire [DATA_W-1:0]  data_i,
  output logic              full_o,
  input  wire               pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == NW'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/dsd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_back
// Line stores, window registers, neighbour selection and squarers.
// ----------------------------------------------------------------------------
module dsd_back #(
  parameter int MAX_WIDTH = dsd_pkg::MAX_WIDTH_DEF,
  parameter int PIX_W     = dsd_pkg::PIXEL_BITS_DEF,
  parameter int QW        = 1 + $clog2(MAX_WIDTH) + PIX_W
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dsd_pkg::frame_cfg_t  cfg_i,
  input  wire                  q_valid_i,
  input  wire [QW-1:0]         q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output dsd_pkg::out_item_t   out_item_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int XW   = ((CW > dsd_pkg::CFG_W) ? CW : dsd_pkg::CFG_W) + 1;
  localparam int SQ_W = 2 * PIX_W;

  logic             q_emit;
  logic [CW-1:0]    q_col;
  logic [PIX_W-1:0] q_x;

  logic [PIX_W-1:0] center_mem [MAX_WIDTH];
  logic [PIX_W-1:0] above_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] center_rd_q, above_rd_q, fwd_data_q;
  logic             fwd_q, pend_q;
  logic [CW-1:0]    pend_col_q;

  logic             s1_valid_q, s1_emit_q;
  logic [PIX_W-1:0] s1_x_q;
  logic             s2_valid_q, s2_last_q;
  logic [PIX_W-1:0] d_left_q, d_up_q, d_ur_q, d_dr_q;
  logic             out_valid_q;

  logic [PIX_W-1:0]             win0_q, win1_q, win2_q;
  logic [CW-1:0]                oc_q;
  logic [dsd_pkg::OUT_ROW_W-1:0] orow_q;

  logic             out_ready, s2_adv, s1_adv, pop, fwd_hit;
  logic             has_left, has_up, has_right, has_down, last;
  logic [PIX_W-1:0] t1, t2, c, left, up, ur, dr;
  logic [XW-1:0]    oc_next;
  logic [SQ_W-1:0]  sq_left, sq_up, sq_ur, sq_dr;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign {q_emit, q_col, q_x} = q_data_i;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_adv    = s2_valid_q && out_ready;
  assign s1_adv    = s1_valid_q && (!s2_valid_q || s2_adv);
  assign pop       = q_valid_i && (!s1_valid_q || s1_adv);
  assign q_pop_o   = pop;

  // the above store is written in the cycle after the pop: forward when a read there hits
  assign fwd_hit = pend_q && (pend_col_q == q_col);

  always_ff @(posedge clk_i) begin
    if (pop) begin
      center_rd_q      <= center_mem[q_col];
      center_mem[q_col] <= q_x;
      above_rd_q       <= above_mem[q_col];
      fwd_data_q       <= center_rd_q;
      fwd_q            <= fwd_hit;
      pend_col_q       <= q_col;
      s1_x_q           <= q_x;
      s1_emit_q        <= q_emit;
    end
    if (pend_q) begin
      above_mem[pend_col_q] <= center_rd_q;
    end
  end

  assign t1 = center_rd_q;
  assign t2 = fwd_q ? fwd_data_q : above_rd_q;

  assign oc_next   = XW'(oc_q) + XW'(1);
  assign has_left  = oc_q != '0;
  assign has_up    = orow_q != '0;
  assign has_right = oc_next < XW'(cfg_i.width);
  assign has_down  = (dsd_pkg::CFG_W'(orow_q) + dsd_pkg::CFG_W'(1)) < cfg_i.height;
  assign last      = !has_right && !has_down;

  assign c    = win0_q;
  assign left = has_left ? win1_q : '0;
  assign up   = has_up ? win2_q : '0;
  assign ur   = (has_up && has_right) ? t2 : '0;
  assign dr   = (has_down && has_right) ? s1_x_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      win0_q     <= '0;
      win1_q     <= '0;
      win2_q     <= '0;
      oc_q       <= '0;
      orow_q     <= '0;
    end else begin
      pend_q <= pop;
      if (pop) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_emit_q) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (cfg_i.restart) begin
        win0_q <= '0;
        win1_q <= '0;
        win2_q <= '0;
        oc_q   <= '0;
        orow_q <= '0;
      end else if (s1_adv) begin
        if (s1_emit_q && last) begin
          // frame complete: clear position and window
          win0_q <= '0;
          win1_q <= '0;
          win2_q <= '0;
          oc_q   <= '0;
          orow_q <= '0;
        end else begin
          win1_q <= win0_q;
          win0_q <= t1;
          win2_q <= t2;
          if (s1_emit_q) begin
            if (!has_right) begin
              oc_q   <= '0;
              orow_q <= orow_q + dsd_pkg::OUT_ROW_W'(1);
            end else begin
              oc_q <= oc_next[CW-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      d_left_q  <= abs_diff(left, c);
      d_up_q    <= abs_diff(up, c);
      d_ur_q    <= abs_diff(ur, c);
      d_dr_q    <= abs_diff(dr, c);
      s2_last_q <= last;
    end
  end

  assign sq_left = SQ_W'(d_left_q) * SQ_W'(d_left_q);
  assign sq_up   = SQ_W'(d_up_q) * SQ_W'(d_up_q);
  assign sq_ur   = SQ_W'(d_ur_q) * SQ_W'(d_ur_q);
  assign sq_dr   = SQ_W'(d_dr_q) * SQ_W'(d_dr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_item_o.diff_left_sq         <= dsd_pkg::RESULT_W'(sq_left);
      out_item_o.diff_up_sq           <= dsd_pkg::RESULT_W'(sq_up);
      out_item_o.diff_up_right_half   <= dsd_pkg::RESULT_W'(sq_ur);
      out_item_o.diff_down_right_half <= dsd_pkg::RESULT_W'(sq_dr);
      out_item_o.frame_end            <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[rtl/dsd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_checker
// Port-level checks of the directional squared difference block.
// ----------------------------------------------------------------------------
module dsd_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input dsd_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed or dropped");

  // final pixel has neither right neighbour, so both diagonal terms match
  a_end_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.frame_end) |->
    (out_item_o.diff_up_right_half == out_item_o.diff_down_right_half))
    else $error("diagonal terms differ on frame end");

  // the queue fills only through an accepted item
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted item");

endmodule

bind directional_squared_difference dsd_checker u_dsd_checker (.*);
`default_nettype wire
